### sv/qmie_pkg.sv
`timescale 1ns / 1ps
// qmie_pkg: shared types and constants for the queue machine instruction executor.
// No dependencies; used by the core and by its port checker.

package qmie_pkg;

   // Sizes of the machine state
   localparam int QUEUE_DEPTH = 1024;
   localparam int NUM_REGS    = 26;
   localparam int WORD_W      = 16;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int RIDX_W      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int DIV_STEPS   = WORD_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   // Command codes
   typedef enum logic [4:0] {
      CMD_PUSH_IMM  = 5'd0,
      CMD_ADD       = 5'd1,
      CMD_SUB       = 5'd2,
      CMD_MUL       = 5'd3,
      CMD_DIV       = 5'd4,
      CMD_MOD       = 5'd5,
      CMD_POP_REG   = 5'd6,
      CMD_PUSH_REG  = 5'd7,
      CMD_PRINT_Q   = 5'd8,
      CMD_PRINT_REG = 5'd9,
      CMD_CHAR_Q    = 5'd10,
      CMD_CHAR_REG  = 5'd11,
      CMD_LABEL     = 5'd12,
      CMD_JUMP      = 5'd13,
      CMD_JZ        = 5'd14,
      CMD_JEQ       = 5'd15,
      CMD_JGT       = 5'd16,
      CMD_QUIT      = 5'd17
   } cmd_type;

   // Fault codes
   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_UNDER = 2'd1,
      FAULT_OVER  = 2'd2
   } fault_type;

   // Instruction word
   typedef struct packed {
      logic [4:0]  command;
      logic [4:0]  reg_first;
      logic [4:0]  reg_second;
      logic [15:0] immediate;
   } req_type;

   // Result word
   typedef struct packed {
      logic        print_valid;
      logic        print_as_char;
      logic [15:0] print_value;
      logic        branch_taken;
      logic        halted;
      logic [1:0]  fault;
   } rsp_type;

endpackage

### sv/queue_machine_instruction_executor_core.sv
`timescale 1ns / 1ps
// Queue machine instruction executor: queue store, register file, sequencer and
// shared ALU with a bit-serial divider. Depends on qmie_pkg.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | qmie_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall | qmie_pkg::rsp_type
//
// One instruction at a time: CHECK, FETCH_A, FETCH_B, EXEC, WRITE, DONE; divide
// and modulo stay in EXEC for a 16-step restoring divide in the shared ALU, and
// a fault in CHECK goes to DONE. The queue store has one read and one write port.
// Reset is synchronous and clears pointers, count and register valid bits.
// The finished word sits in an output register; a stalled result only holds the
// sequencer when the next result is ready to be loaded.

module queue_machine_instruction_executor_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qmie_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qmie_pkg::rsp_type rsp_data
);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_CHECK   = 7'b0000010,
      S_FETCH_A = 7'b0000100,
      S_FETCH_B = 7'b0001000,
      S_EXEC    = 7'b0010000,
      S_WRITE   = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   localparam int QP = qmie_pkg::QPTR_W;
   localparam int QC = qmie_pkg::QCNT_W;
   localparam int RI = qmie_pkg::RIDX_W;
   localparam int SW = qmie_pkg::STEP_W;

   // Registers
   state_type         state_ff, state_in;
   qmie_pkg::req_type req_ff, req_in;
   logic [QP-1:0]     head_ff, head_in;
   logic [QP-1:0]     tail_ff, tail_in;
   logic [QC-1:0]     count_ff, count_in;
   logic [15:0]       a_ff, a_in;
   logic [15:0]       b_ff, b_in;
   logic [15:0]       rem_ff, rem_in;
   logic [15:0]       res_ff, res_in;
   logic [SW-1:0]     step_ff, step_in;
   logic [1:0]        fault_ff, fault_in;
   qmie_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Storage
   logic [15:0]       qmem [qmie_pkg::QUEUE_DEPTH];
   logic [15:0]       q_rdata_ff;
   logic [15:0]       rmem [qmie_pkg::NUM_REGS];
   logic [qmie_pkg::NUM_REGS-1:0] rvalid_ff;
   logic [15:0]       r_rdata_ff;
   logic              r_rok_ff;

   // Decode of the held instruction
   logic        is_arith, is_divmod, pops_one, adds, uses_q;
   logic [1:0]  need;
   logic [QP-1:0] q_raddr;
   logic [4:0]  r_raddr;
   logic [15:0] r_rd;
   logic        q_we, r_we;
   logic [15:0] q_wdata, div_res;
   logic [31:0] product;
   logic [16:0] trial;
   logic        ge;

   function automatic logic [QP-1:0] next_ptr(input logic [QP-1:0] p);
      return (p == QP'(qmie_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic reg_ok(input logic [4:0] idx);
      return 32'(idx) < qmie_pkg::NUM_REGS;
   endfunction

   always_comb begin
      is_divmod = (req_ff.command == qmie_pkg::CMD_DIV) || (req_ff.command == qmie_pkg::CMD_MOD);
      is_arith  = (req_ff.command == qmie_pkg::CMD_ADD) || (req_ff.command == qmie_pkg::CMD_SUB)
                  || (req_ff.command == qmie_pkg::CMD_MUL) || is_divmod;
      pops_one  = (req_ff.command == qmie_pkg::CMD_POP_REG)
                  || (req_ff.command == qmie_pkg::CMD_PRINT_Q)
                  || (req_ff.command == qmie_pkg::CMD_CHAR_Q);
      adds      = (req_ff.command == qmie_pkg::CMD_PUSH_IMM)
                  || (req_ff.command == qmie_pkg::CMD_PUSH_REG);
      uses_q    = is_arith || pops_one;
      need      = is_arith ? 2'd2 : (pops_one ? 2'd1 : 2'd0);
   end

   // Read addresses: first operand in CHECK, second in FETCH_A
   assign q_raddr = (state_ff == S_FETCH_A) ? next_ptr(head_ff) : head_ff;
   assign r_raddr = (state_ff == S_FETCH_A) ? req_ff.reg_second : req_ff.reg_first;
   assign r_rd    = r_rok_ff ? r_rdata_ff : 16'd0;

   // Shared ALU: one restoring divide step, plus add, sub and multiply
   assign product = a_ff * b_ff;
   assign trial   = {rem_ff, a_ff[15]};
   assign ge      = trial >= {1'b0, b_ff};
   assign div_res = (b_ff == 16'd0) ? 16'd0
                  : ((req_ff.command == qmie_pkg::CMD_DIV) ? a_ff : rem_ff);

   // Write ports
   assign q_we    = (state_ff == S_WRITE) && (is_arith || adds);
   assign q_wdata = is_divmod ? div_res : res_ff;
   assign r_we    = (state_ff == S_WRITE) && (req_ff.command == qmie_pkg::CMD_POP_REG)
                    && reg_ok(req_ff.reg_first);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      step_in      = step_ff;
      fault_in     = fault_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      // output word leaves
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               fault_in = qmie_pkg::FAULT_NONE;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (count_ff < QC'(need)) begin
               fault_in = qmie_pkg::FAULT_UNDER;
               state_in = S_DONE;
            end else if (adds && (count_ff == QC'(qmie_pkg::QUEUE_DEPTH))) begin
               fault_in = qmie_pkg::FAULT_OVER;
               state_in = S_DONE;
            end else begin
               state_in = S_FETCH_A;
            end
         end
         S_FETCH_A: begin
            a_in = uses_q ? q_rdata_ff : r_rd;
            if (uses_q) begin
               head_in  = next_ptr(head_ff);
               count_in = count_ff - 1'b1;
            end
            state_in = S_FETCH_B;
         end
         S_FETCH_B: begin
            b_in = is_arith ? q_rdata_ff : r_rd;
            if (is_arith) begin
               head_in  = next_ptr(head_ff);
               count_in = count_ff - 1'b1;
            end
            rem_in   = '0;
            step_in  = '0;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (is_divmod) begin
               // one quotient bit per cycle, quotient shifts into a
               rem_in  = ge ? 16'(trial - {1'b0, b_ff}) : trial[15:0];
               a_in    = {a_ff[14:0], ge};
               step_in = step_ff + 1'b1;
               if (step_ff == SW'(qmie_pkg::DIV_STEPS - 1)) begin
                  state_in = S_WRITE;
               end
            end else begin
               unique case (req_ff.command)
                  qmie_pkg::CMD_ADD:      res_in = a_ff + b_ff;
                  qmie_pkg::CMD_SUB:      res_in = a_ff - b_ff;
                  qmie_pkg::CMD_MUL:      res_in = product[15:0];
                  qmie_pkg::CMD_PUSH_IMM: res_in = req_ff.immediate;
                  default:                res_in = a_ff;
               endcase
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (q_we) begin
               tail_in  = next_ptr(tail_ff);
               count_in = count_ff + 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = '0;
               rsp_in.fault = fault_ff;
               if (fault_ff == qmie_pkg::FAULT_NONE) begin
                  unique case (req_ff.command)
                     qmie_pkg::CMD_PRINT_Q, qmie_pkg::CMD_PRINT_REG: begin
                        rsp_in.print_valid = 1'b1;
                        rsp_in.print_value = a_ff;
                     end
                     qmie_pkg::CMD_CHAR_Q, qmie_pkg::CMD_CHAR_REG: begin
                        rsp_in.print_valid   = 1'b1;
                        rsp_in.print_as_char = 1'b1;
                        rsp_in.print_value   = {8'd0, a_ff[7:0]};
                     end
                     qmie_pkg::CMD_JUMP: rsp_in.branch_taken = 1'b1;
                     qmie_pkg::CMD_JZ:   rsp_in.branch_taken = (a_ff == 16'd0);
                     qmie_pkg::CMD_JEQ:  rsp_in.branch_taken = (a_ff == b_ff);
                     qmie_pkg::CMD_JGT:  rsp_in.branch_taken = (a_ff > b_ff);
                     qmie_pkg::CMD_QUIT: rsp_in.halted = 1'b1;
                     default: ;
                  endcase
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rvalid_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (r_we) begin
            rvalid_ff[RI'(req_ff.reg_first)] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      rem_ff   <= rem_in;
      res_ff   <= res_in;
      step_ff  <= step_in;
      fault_ff <= fault_in;
      rsp_ff   <= rsp_in;
   end

   // Queue store: one write, one registered read
   always_ff @(posedge clock) begin
      if (q_we) begin
         qmem[tail_ff] <= q_wdata;
      end
      q_rdata_ff <= qmem[q_raddr];
   end

   // Register file: unwritten entries read as zero through the valid bits
   always_ff @(posedge clock) begin
      if (r_we) begin
         rmem[RI'(req_ff.reg_first)] <= a_ff;
      end
      r_rdata_ff <= rmem[RI'(r_raddr)];
      r_rok_ff   <= reg_ok(r_raddr) && rvalid_ff[RI'(r_raddr)];
   end

   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### sv/qmie_checker.sv
`timescale 1ns / 1ps
// qmie_checker: port-level assertions for the instruction executor core.
// Depends on qmie_pkg; bound to queue_machine_instruction_executor_core below.

module qmie_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input qmie_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input qmie_pkg::rsp_type rsp_data
);

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // A faulting instruction reports nothing else
   a_fault_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.fault != qmie_pkg::FAULT_NONE)
      |-> !rsp_data.print_valid && !rsp_data.branch_taken && !rsp_data.halted
          && (rsp_data.print_value == 16'd0))
      else $error("faulting word carries other fields");

   // A character print carries only the low byte
   a_char_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.print_as_char
      |-> rsp_data.print_valid && (rsp_data.print_value[15:8] == 8'd0))
      else $error("character print out of range");

   // One instruction at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while busy");

endmodule

bind queue_machine_instruction_executor_core qmie_checker u_qmie_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
